/* sv/twd_pkg.sv */
// package for the timeline event window dispatcher
// holds the result kinds, command and register codes, back end states and the queue word format
`timescale 1ns / 1ps
`default_nettype none

package twd_pkg;

    localparam logic       CMD_LOAD        = 1'b0;
    localparam logic       CMD_ADVANCE     = 1'b1;

    localparam logic [1:0] REG_PLAY_LENGTH = 2'd0;
    localparam logic [1:0] REG_ENTRY_COUNT = 2'd1;
    localparam logic [1:0] REG_SHORT_EPS   = 2'd2;

    typedef enum logic [2:0] {
        KIND_DONE    = 3'd0,
        KIND_INSTANT = 3'd1,
        KIND_BEGIN   = 3'd2,
        KIND_TICK    = 3'd3,
        KIND_END     = 3'd4
    } t_kind;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CLAMP,
        ST_DUR,
        ST_HIT,
        ST_EMIT,
        ST_DONE
    } t_state;

    // one classified word between front and back
    typedef struct packed {
        logic               is_adv;
        logic [2:0]         slot;
        logic [31:0]        start;
        logic [31:0]        length;
        logic [1:0]         nseg;
        logic               rev;
        logic               step_nz;
        logic [30:0]        amt;
        logic signed [32:0] lo0;
        logic signed [32:0] hi0;
        logic signed [32:0] lo1;
        logic signed [32:0] hi1;
    } t_desc;

    typedef struct packed {
        logic  valid;
        t_desc desc;
    } t_q_head;

endpackage

`default_nettype wire

/* sv/timeline_event_window_dispatcher.sv */
// top level of the timeline event window dispatcher: configuration port,
// front end queue and back end walker; depends on twd_pkg, twd_front, twd_back
//
// usage: input words arrive on i_in_valid / o_in_ready, results leave on
// o_out_valid / i_out_ready; registers play_length (0x0), entry_count (0x4)
// and short_epsilon (0x8) are written through the apb port; the user must
// do so only while idle, the block does not enforce it; a load word writes
// one table entry and gives no result; an advance walks its nseg window
// segments (0 to 2) over the count examined entries, using the per entry
// clamp, duration, crossing and emit steps of the back end
// the two deep queue takes further words while the back end is busy
// results come from one output register; a stalled receiver holds it and
// the walk waits, words still enter the queue until it is full
// the done word closes every advance with last high
// reset clears the queue, the walker and the registers (short_epsilon to 7);
// table entries are undefined until loaded
`timescale 1ns / 1ps
`default_nettype none

module timeline_event_window_dispatcher #(
    parameter int TABLE_DEPTH = 8
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 psel,
    input  wire logic                 penable,
    input  wire logic                 pwrite,
    input  wire logic [3:0]           paddr,
    input  wire logic [31:0]          pwdata,
    output logic [31:0]               prdata,
    output logic                      pready,
    input  wire logic                 i_in_valid,
    output logic                      o_in_ready,
    input  wire logic                 i_cmd,
    input  wire logic [2:0]           i_entry_slot,
    input  wire logic signed [31:0]   i_entry_start,
    input  wire logic signed [31:0]   i_entry_length,
    input  wire logic signed [31:0]   i_prev_time,
    input  wire logic signed [31:0]   i_cur_time,
    input  wire logic                 i_wrapped,
    input  wire logic                 i_backward,
    input  wire logic signed [31:0]   i_step_time,
    output logic                      o_out_valid,
    input  wire logic                 i_out_ready,
    output logic [2:0]                o_event_kind,
    output logic [2:0]                o_event_slot,
    output logic [30:0]               o_tick_amount,
    output logic                      o_last
);

    logic [30:0] r_play_length;
    logic [3:0]  r_entry_count;
    logic [15:0] r_short_eps;
    logic        w_cfg_wr;
    twd_pkg::t_q_head w_head;
    logic        w_pop;

    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_play_length <= 31'd0;
            r_entry_count <= 4'd0;
            r_short_eps   <= 16'd7;
        end else if (w_cfg_wr) begin
            unique case (paddr[3:2])
                twd_pkg::REG_PLAY_LENGTH: r_play_length <= pwdata[30:0];
                twd_pkg::REG_ENTRY_COUNT: r_entry_count <= pwdata[3:0];
                twd_pkg::REG_SHORT_EPS:   r_short_eps   <= pwdata[15:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        unique case (paddr[3:2])
            twd_pkg::REG_PLAY_LENGTH: prdata = {1'b0, r_play_length};
            twd_pkg::REG_ENTRY_COUNT: prdata = {28'd0, r_entry_count};
            twd_pkg::REG_SHORT_EPS:   prdata = {16'd0, r_short_eps};
            default:                  prdata = 32'd0;
        endcase
    end

    twd_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_in_valid),
        .o_ready        (o_in_ready),
        .i_cmd          (i_cmd),
        .i_entry_slot   (i_entry_slot),
        .i_entry_start  (i_entry_start),
        .i_entry_length (i_entry_length),
        .i_prev_time    (i_prev_time),
        .i_cur_time     (i_cur_time),
        .i_wrapped      (i_wrapped),
        .i_backward     (i_backward),
        .i_step_time    (i_step_time),
        .i_play_length  (r_play_length),
        .i_entry_count  (r_entry_count),
        .i_short_eps    (r_short_eps),
        .o_head         (w_head),
        .i_pop          (w_pop)
    );

    twd_back #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_head         (w_head),
        .o_pop          (w_pop),
        .i_play_length  (r_play_length),
        .i_entry_count  (r_entry_count),
        .i_short_eps    (r_short_eps),
        .o_valid        (o_out_valid),
        .i_ready        (i_out_ready),
        .o_event_kind   (o_event_kind),
        .o_event_slot   (o_event_slot),
        .o_tick_amount  (o_tick_amount),
        .o_last         (o_last)
    );

    a_last_is_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_last) |-> (o_event_kind == twd_pkg::KIND_DONE))
        else $error("last set on a word that is not done");

    a_amt_only_tick: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_event_kind != twd_pkg::KIND_TICK) |-> (o_tick_amount == 31'd0))
        else $error("tick amount on a word that is not a tick");

    a_done_slot_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_event_kind == twd_pkg::KIND_DONE) |-> (o_event_slot == 3'd0 && o_last))
        else $error("done word without last or with a slot");

    a_pop_needs_head: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop |-> w_head.valid)
        else $error("queue popped while empty");

endmodule

`default_nettype wire

/* sv/twd_front.sv */
// front end: accepts input words, classifies them into segment descriptors
// and holds them in a two deep queue; depends on twd_pkg
`timescale 1ns / 1ps
`default_nettype none

module twd_front (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_valid,
    output logic                      o_ready,
    input  wire logic                 i_cmd,
    input  wire logic [2:0]           i_entry_slot,
    input  wire logic signed [31:0]   i_entry_start,
    input  wire logic signed [31:0]   i_entry_length,
    input  wire logic signed [31:0]   i_prev_time,
    input  wire logic signed [31:0]   i_cur_time,
    input  wire logic                 i_wrapped,
    input  wire logic                 i_backward,
    input  wire logic signed [31:0]   i_step_time,
    input  wire logic [30:0]          i_play_length,
    input  wire logic [3:0]           i_entry_count,
    input  wire logic [15:0]          i_short_eps,
    output twd_pkg::t_q_head          o_head,
    input  wire logic                 i_pop
);

    twd_pkg::t_desc r_q [2];
    logic           r_wr;
    logic           r_rd;
    logic [1:0]     r_cnt;
    twd_pkg::t_desc w_desc;
    logic           w_push;
    logic           w_pop;

    logic signed [32:0] w_prev33;
    logic signed [32:0] w_cur33;
    logic signed [32:0] w_len33;
    logic signed [32:0] w_eps33;

    assign w_prev33 = {i_prev_time[31], i_prev_time};
    assign w_cur33  = {i_cur_time[31], i_cur_time};
    assign w_len33  = signed'({2'b00, i_play_length});
    assign w_eps33  = signed'({17'd0, i_short_eps});

    always_comb begin
        w_desc         = '0;
        w_desc.is_adv  = (i_cmd == twd_pkg::CMD_ADVANCE);
        w_desc.slot    = i_entry_slot;
        w_desc.start   = i_entry_start;
        w_desc.length  = i_entry_length;
        w_desc.rev     = i_backward;
        w_desc.step_nz = (i_step_time != 32'sd0);
        if (i_step_time[31]) begin
            w_desc.amt = (i_step_time == 32'sh8000_0000) ? 31'h7fff_ffff
                                                         : 31'(-i_step_time);
        end else begin
            w_desc.amt = i_step_time[30:0];
        end
        if (i_play_length == 31'd0 || i_entry_count == 4'd0) begin
            w_desc.nseg = 2'd0;
        end else if (!i_wrapped) begin
            w_desc.nseg = 2'd1;
        end else begin
            w_desc.nseg = 2'd2;
        end
        w_desc.lo0 = w_prev33;
        w_desc.hi0 = w_cur33;
        w_desc.lo1 = w_prev33;
        w_desc.hi1 = w_cur33;
        if (i_wrapped) begin
            if (!i_backward) begin
                w_desc.hi0 = w_len33;
                w_desc.lo1 = -w_eps33;
            end else begin
                w_desc.hi0 = 33'sd0;
                w_desc.lo1 = w_len33 + w_eps33;
            end
        end
    end

    assign o_ready = (r_cnt != 2'd2);
    assign w_push  = i_valid && o_ready;
    assign w_pop   = i_pop && (r_cnt != 2'd0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= 1'b0;
            r_rd  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_push) begin
                r_wr <= ~r_wr;
            end
            if (w_pop) begin
                r_rd <= ~r_rd;
            end
            r_cnt <= r_cnt + {1'b0, w_push} - {1'b0, w_pop};
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wr] <= w_desc;
        end
    end

    assign o_head.valid = (r_cnt != 2'd0);
    assign o_head.desc  = r_q[r_rd];

endmodule

`default_nettype wire

/* sv/twd_back.sv */
// back end: event table, per entry walk over the window segments and the
// result register; depends on twd_pkg and the queue head of twd_front
`timescale 1ns / 1ps
`default_nettype none

module twd_back #(
    parameter int TABLE_DEPTH = 8
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire twd_pkg::t_q_head     i_head,
    output logic                      o_pop,
    input  wire logic [30:0]          i_play_length,
    input  wire logic [3:0]           i_entry_count,
    input  wire logic [15:0]          i_short_eps,
    output logic                      o_valid,
    input  wire logic                 i_ready,
    output logic [2:0]                o_event_kind,
    output logic [2:0]                o_event_slot,
    output logic [30:0]               o_tick_amount,
    output logic                      o_last
);

    localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int MAX_C = (TABLE_DEPTH < 8) ? TABLE_DEPTH : 8;

    logic [31:0] r_start [TABLE_DEPTH];
    logic [31:0] r_len   [TABLE_DEPTH];

    twd_pkg::t_state r_state, n_state;
    logic            r_seg, n_seg;
    logic [2:0]      r_idx, n_idx;
    logic [30:0]     r_s, n_s;
    logic [30:0]     r_e, n_e;
    logic            r_short, n_short;
    logic signed [32:0] r_rawend, n_rawend;
    logic [2:0]      r_pend, n_pend;
    twd_pkg::t_kind  r_k0, n_k0;
    twd_pkg::t_kind  r_k1, n_k1;
    twd_pkg::t_kind  r_k2, n_k2;

    logic            r_out_valid, n_out_valid;
    twd_pkg::t_kind  r_kind, n_kind;
    logic [2:0]      r_slot, n_slot;
    logic [30:0]     r_amt, n_amt;
    logic            r_last, n_last;

    twd_pkg::t_desc  w_d;
    logic [3:0]      w_count;
    logic [3:0]      w_idx4;
    logic [3:0]      w_slot4;
    logic            w_wr;
    logic            w_free;
    logic signed [31:0] w_rs, w_rl;
    logic signed [32:0] w_rs33, w_rl33, w_len33, w_eps33;
    logic [30:0]     w_room;
    logic signed [32:0] w_room33, w_srl, w_s33, w_e33, w_lo, w_hi;
    logic [30:0]     w_dur;
    logic            w_active, w_hs, w_he, w_tick, w_last_idx, w_last_seg;

    assign w_d     = i_head.desc;
    assign w_count = (i_entry_count > 4'(MAX_C)) ? 4'(MAX_C) : i_entry_count;
    assign w_idx4  = {1'b0, r_idx};
    assign w_slot4 = {1'b0, w_d.slot};
    assign w_rs    = signed'(r_start[w_idx4[IDX_W-1:0]]);
    assign w_rl    = signed'(r_len[w_idx4[IDX_W-1:0]]);
    assign w_rs33  = {w_rs[31], w_rs};
    assign w_rl33  = {w_rl[31], w_rl};
    assign w_len33 = signed'({2'b00, i_play_length});
    assign w_eps33 = signed'({17'd0, i_short_eps});
    assign w_room  = i_play_length - r_s;
    assign w_room33 = signed'({2'b00, w_room});
    assign w_srl   = signed'({2'b00, r_s}) + w_rl33;
    assign w_s33   = signed'({2'b00, r_s});
    assign w_e33   = signed'({2'b00, r_e});
    assign w_lo    = r_seg ? w_d.lo1 : w_d.lo0;
    assign w_hi    = r_seg ? w_d.hi1 : w_d.hi0;
    assign w_free  = !r_out_valid || i_ready;
    assign w_last_idx = ({1'b0, r_idx} + 4'd1 == w_count);
    assign w_last_seg = r_seg || (w_d.nseg == 2'd1);

    assign w_dur = w_rl[31] ? 31'd0 : ((w_rl33 > w_room33) ? w_room : w_rl[30:0]);
    assign w_active = (w_rl33 > w_eps33) && (w_rs33 <= w_hi) && (w_hi < r_rawend);

    always_comb begin
        if (!w_d.rev) begin
            w_hs = (w_lo < w_s33) && (w_s33 <= w_hi);
            w_he = (w_lo < w_e33) && (w_e33 <= w_hi);
            w_tick = w_d.step_nz && (w_hs || w_active);
        end else begin
            w_hs = (w_hi <= w_s33) && (w_s33 < w_lo);
            w_he = (w_hi <= w_e33) && (w_e33 < w_lo);
            w_tick = w_d.step_nz && (w_he || w_active);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= twd_pkg::ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_seg    <= n_seg;
        r_idx    <= n_idx;
        r_s      <= n_s;
        r_e      <= n_e;
        r_short  <= n_short;
        r_rawend <= n_rawend;
        r_pend   <= n_pend;
        r_k0     <= n_k0;
        r_k1     <= n_k1;
        r_k2     <= n_k2;
        r_kind   <= n_kind;
        r_slot   <= n_slot;
        r_amt    <= n_amt;
        r_last   <= n_last;
        if (w_wr) begin
            r_start[w_slot4[IDX_W-1:0]] <= w_d.start;
            r_len[w_slot4[IDX_W-1:0]]   <= w_d.length;
        end
    end

    always_comb begin
        n_state     = r_state;
        n_seg       = r_seg;
        n_idx       = r_idx;
        n_s         = r_s;
        n_e         = r_e;
        n_short     = r_short;
        n_rawend    = r_rawend;
        n_pend      = r_pend;
        n_k0        = r_k0;
        n_k1        = r_k1;
        n_k2        = r_k2;
        n_out_valid = r_out_valid && !i_ready;
        n_kind      = r_kind;
        n_slot      = r_slot;
        n_amt       = r_amt;
        n_last      = r_last;
        o_pop       = 1'b0;
        w_wr        = 1'b0;
        unique case (r_state)
            twd_pkg::ST_IDLE: begin
                if (i_head.valid) begin
                    if (!w_d.is_adv) begin
                        w_wr  = (w_slot4 < 4'(TABLE_DEPTH));
                        o_pop = 1'b1;
                    end else if (w_d.nseg == 2'd0) begin
                        n_state = twd_pkg::ST_DONE;
                    end else begin
                        n_seg   = 1'b0;
                        n_idx   = 3'd0;
                        n_state = twd_pkg::ST_CLAMP;
                    end
                end
            end
            twd_pkg::ST_CLAMP: begin
                if (w_rs[31]) begin
                    n_s = 31'd0;
                end else if (w_rs33 > w_len33) begin
                    n_s = i_play_length;
                end else begin
                    n_s = w_rs[30:0];
                end
                n_rawend = w_rs33 + w_rl33;
                n_state  = twd_pkg::ST_DUR;
            end
            twd_pkg::ST_DUR: begin
                if (w_rl[31]) begin
                    n_e = r_s;
                end else if (w_rl33 > w_room33) begin
                    n_e = i_play_length;
                end else begin
                    n_e = w_srl[30:0];
                end
                n_short = (w_dur <= {15'd0, i_short_eps});
                n_state = twd_pkg::ST_HIT;
            end
            twd_pkg::ST_HIT: begin
                if (r_short) begin
                    n_pend = {2'b00, w_hs};
                    n_k0   = twd_pkg::KIND_INSTANT;
                end else if (!w_d.rev) begin
                    n_pend = {w_he, w_tick, w_hs};
                    n_k0   = twd_pkg::KIND_BEGIN;
                    n_k2   = twd_pkg::KIND_END;
                end else begin
                    n_pend = {w_hs, w_tick, w_he};
                    n_k0   = twd_pkg::KIND_END;
                    n_k2   = twd_pkg::KIND_BEGIN;
                end
                n_k1    = twd_pkg::KIND_TICK;
                n_state = twd_pkg::ST_EMIT;
            end
            twd_pkg::ST_EMIT: begin
                if (r_pend == 3'd0) begin
                    if (!w_last_idx) begin
                        n_idx   = r_idx + 3'd1;
                        n_state = twd_pkg::ST_CLAMP;
                    end else if (!w_last_seg) begin
                        n_idx   = 3'd0;
                        n_seg   = 1'b1;
                        n_state = twd_pkg::ST_CLAMP;
                    end else begin
                        n_state = twd_pkg::ST_DONE;
                    end
                end else if (w_free) begin
                    n_out_valid = 1'b1;
                    n_slot      = r_idx;
                    n_last      = 1'b0;
                    n_amt       = 31'd0;
                    priority if (r_pend[0]) begin
                        n_kind    = r_k0;
                        n_pend[0] = 1'b0;
                    end else if (r_pend[1]) begin
                        n_kind    = r_k1;
                        n_amt     = w_d.amt;
                        n_pend[1] = 1'b0;
                    end else begin
                        n_kind    = r_k2;
                        n_pend[2] = 1'b0;
                    end
                end
            end
            twd_pkg::ST_DONE: begin
                if (w_free) begin
                    n_out_valid = 1'b1;
                    n_kind      = twd_pkg::KIND_DONE;
                    n_slot      = 3'd0;
                    n_amt       = 31'd0;
                    n_last      = 1'b1;
                    o_pop       = 1'b1;
                    n_state     = twd_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = twd_pkg::ST_IDLE;
            end
        endcase
    end

    assign o_valid       = r_out_valid;
    assign o_event_kind  = r_kind;
    assign o_event_slot  = r_slot;
    assign o_tick_amount = r_amt;
    assign o_last        = r_last;

endmodule

`default_nettype wire
